// File: src/svf_pkg.sv
// Shared types and constants for the state-variable filter core.
// No dependencies; imported by svf_mul and state_variable_filter_core.
`default_nettype none

package svf_pkg;

  localparam int COEF_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_G    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_BYPASS = 2'd0,
    MODE_LP     = 2'd1,
    MODE_BP     = 2'd2,
    MODE_HP     = 2'd3
  } mode_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_V3   = 8'b0000_0010,
    ST_A2   = 8'b0000_0100,
    ST_V1   = 8'b0000_1000,
    ST_G    = 8'b0001_0000,
    ST_V2   = 8'b0010_0000,
    ST_Y    = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// File: src/svf_mul.sv
// Shared coefficient multiplier: unsigned coefficient times signed operand,
// full product registered. Depends on svf_pkg.
`default_nettype none

module svf_mul #(
  parameter int OPND_W = 32
) (
  input  wire logic                                  clk,
  input  wire logic [svf_pkg::COEF_W-1:0]            coef,
  input  wire logic signed [OPND_W-1:0]              opnd,
  output logic signed [OPND_W+svf_pkg::COEF_W:0]     prod_r
);
  import svf_pkg::*;

  logic signed [OPND_W+COEF_W:0] prod_nxt;

  assign prod_nxt = $signed({1'b0, coef}) * opnd;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

// File: src/state_variable_filter_core.sv
// Trapezoidal state-variable filter core: one sample in, one sample out.
// Each word passes through states V3, A2, V1, G, V2, Y and OUT (bypass: OUT
// only); a new word is taken only in IDLE, as the single shared multiplier
// steps through the four coefficient products in turn.
// Reset (rst_n low, synchronous) clears mode, coefficients and both states.
// Uses svf_pkg and svf_mul.
`default_nettype none

module state_variable_filter_core #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // in_tdata: [SAMPLE_WIDTH-1:0] sample_in, zero pad above
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     in_tdata,
  // out_tdata: [SAMPLE_WIDTH-1:0] sample_out, zero pad above
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          out_tdata,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [svf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [svf_pkg::COEF_W-1:0]            cfg_data
);
  import svf_pkg::*;

  localparam int TDW  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int STW  = SAMPLE_WIDTH + 8;
  localparam int PW   = STW + COEF_W + 1;
  localparam int SUMW = PW + 2;

  localparam logic signed [PW-1:0] RND_HALF =
    {{(PW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [SUMW-1:0] ST_MAX =
    {{(SUMW-STW+1){1'b0}}, {(STW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] ST_MIN =
    {{(SUMW-STW+1){1'b1}}, {(STW-1){1'b0}}};
  localparam logic signed [SUMW-1:0] SMP_MAX =
    {{(SUMW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SMP_MIN =
    {{(SUMW-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  function automatic logic signed [STW-1:0] sat_st(input logic signed [SUMW-1:0] v);
    logic signed [STW-1:0] r;
    if (v > ST_MAX) begin
      r = ST_MAX[STW-1:0];
    end else if (v < ST_MIN) begin
      r = ST_MIN[STW-1:0];
    end else begin
      r = v[STW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_smp(
    input logic signed [SUMW-1:0] v);
    logic signed [SAMPLE_WIDTH-1:0] r;
    if (v > SMP_MAX) begin
      r = SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (v < SMP_MIN) begin
      r = SMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      r = v[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

  // configuration
  mode_t               mode_r;
  logic [COEF_W-1:0]   g_r, k_r, a1_r, a2_r;

  // sequencer and datapath
  state_t                         state_r, state_nxt;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [STW-1:0]          band_r, low_r, v3_r, v1_r, v2_r;
  logic signed [PW-1:0]           acc_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r;
  logic                           out_valid_r;
  logic [SAMPLE_WIDTH-1:0]        out_data_r;

  logic [COEF_W-1:0]              mul_coef;
  logic signed [STW-1:0]          mul_opnd;
  logic signed [PW-1:0]           prod_r;
  logic signed [PW-1:0]           rnd;
  logic signed [SUMW-1:0]         y_sel;
  logic                           in_acc, out_free;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'(out_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BYPASS;
      g_r    <= '0;
      k_r    <= '0;
      a1_r   <= '0;
      a2_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: mode_r <= mode_t'(cfg_data[MODE_W-1:0]);
        REG_G:    g_r    <= cfg_data;
        REG_K:    k_r    <= cfg_data;
        REG_A1:   a1_r   <= cfg_data;
        REG_A2:   a2_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier; product is registered and lands in the next cycle
  always_comb begin
    case (state_r)
      ST_A2: begin
        mul_coef = a2_r;
        mul_opnd = v3_r;
      end
      ST_G: begin
        mul_coef = g_r;
        mul_opnd = v1_r;
      end
      ST_V2: begin
        mul_coef = k_r;
        mul_opnd = v1_r;
      end
      default: begin
        mul_coef = a1_r;
        mul_opnd = band_r;
      end
    endcase
  end

  svf_mul #(
    .OPND_W (STW)
  ) u_mul (
    .clk    (clk),
    .coef   (mul_coef),
    .opnd   (mul_opnd),
    .prod_r (prod_r)
  );

  // round to nearest, ties up
  assign rnd = (prod_r + RND_HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    case (mode_r)
      MODE_HP: y_sel = SUMW'(x_r) - SUMW'(rnd) - SUMW'(v2_r);
      MODE_BP: y_sel = SUMW'(v1_r);
      default: y_sel = SUMW'(v2_r);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (mode_r == MODE_BYPASS) ? ST_OUT : ST_V3;
        end
      end
      ST_V3:  state_nxt = ST_A2;
      ST_A2:  state_nxt = ST_V1;
      ST_V1:  state_nxt = ST_G;
      ST_G:   state_nxt = ST_V2;
      ST_V2:  state_nxt = ST_Y;
      ST_Y:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      band_r      <= '0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // a new word may replace the one taken at this edge
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_G:    band_r <= sat_st(SUMW'(v1_r) + SUMW'(v1_r) - SUMW'(band_r));
        ST_Y:    low_r  <= sat_st(SUMW'(v2_r) + SUMW'(v2_r) - SUMW'(low_r));
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_r <= in_tdata[SAMPLE_WIDTH-1:0];
          y_r <= in_tdata[SAMPLE_WIDTH-1:0];
        end
      end
      ST_V3: v3_r  <= sat_st(SUMW'(x_r) - SUMW'(low_r));
      ST_A2: acc_r <= rnd;
      ST_V1: v1_r  <= sat_st(SUMW'(acc_r) + SUMW'(rnd));
      ST_V2: v2_r  <= sat_st(SUMW'(low_r) + SUMW'(rnd));
      ST_Y:  y_r   <= sat_smp(y_sel);
      ST_OUT: begin
        if (out_free) begin
          out_data_r <= y_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
